### rtl/core/dwr_pkg.sv
// shared types and constants for the deque with reverse flag
package dwr_pkg;

    localparam int COUNT_W = 11;
    localparam int VALUE_W = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_DELETE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    // operations issued by the controller to the datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic load;
        logic flip;
        logic remove;
        logic fault;
    } t_dp_ctrl;

    // datapath flags seen by the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic error;
    } t_dp_stat;

endpackage

### rtl/core/dwr_ctrl.sv
// request controller: decodes commands, sequences result handshake
module dwr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_command,
    input  dwr_pkg::t_dp_stat i_stat,
    output dwr_pkg::t_dp_ctrl o_ctrl,
    output logic [1:0]        o_status
);
    import dwr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state   r_state;
    t_status  r_status;
    t_status  n_status;
    t_cmd     cmd;
    logic     accept;
    t_dp_ctrl ctrl;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign cmd    = t_cmd'(i_command);

    always_comb begin
        ctrl     = '0;
        n_status = ST_OK;
        if (accept) begin
            ctrl.accept = 1'b1;
            if (cmd == CMD_CLEAR) begin
                ctrl.clear = 1'b1;
            end else if (i_stat.error) begin
                n_status = ST_IGNORED;
            end else begin
                unique case (cmd)
                    CMD_LOAD: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            ctrl.load = 1'b1;
                        end
                    end
                    CMD_REVERSE: begin
                        ctrl.flip = 1'b1;
                    end
                    CMD_DELETE: begin
                        if (i_stat.empty) begin
                            n_status   = ST_EMPTY;
                            ctrl.fault = 1'b1;
                        end else begin
                            ctrl.remove = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state  <= S_HOLD;
                        r_status <= n_status;
                    end
                end
                S_HOLD: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ctrl      = ctrl;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_status    = r_status;

endmodule

### rtl/core/dwr_datapath.sv
// element store, pointers, count and orientation/error flags
module dwr_datapath #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dwr_pkg::t_dp_ctrl         i_ctrl,
    input  logic [dwr_pkg::VALUE_W-1:0] i_value,
    output dwr_pkg::t_dp_stat         o_stat,
    output logic [dwr_pkg::VALUE_W-1:0] o_removed_value,
    output logic [dwr_pkg::COUNT_W-1:0] o_count,
    output logic                      o_reversed
);
    import dwr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_rd_live;
    logic [AW-1:0]         r_front;
    logic [CW-1:0]         r_count;
    logic                  r_rev;
    logic                  r_err;

    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [SW-1:0] tail_slot;
    logic [SW-1:0] last_slot;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] head_next;

    // physical slots past the head, wrapped once (sum stays below twice the depth)
    always_comb begin
        tail_sum  = SW'(r_front) + SW'(r_count);
        last_sum  = SW'(r_front) + SW'(r_count - 1'b1);
        tail_slot = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
        last_slot = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
        wr_addr   = tail_slot[AW-1:0];
        rd_addr   = r_rev ? last_slot[AW-1:0] : r_front;
        head_next = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mem[wr_addr] <= DATA_WIDTH'(i_value);
        end
        if (i_ctrl.remove) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_err     <= 1'b0;
            r_rd_live <= 1'b0;
        end else if (i_ctrl.accept) begin
            r_rd_live <= i_ctrl.remove;
            if (i_ctrl.clear) begin
                r_front <= '0;
                r_count <= '0;
                r_rev   <= 1'b0;
                r_err   <= 1'b0;
            end
            if (i_ctrl.load) begin
                r_count <= r_count + 1'b1;
            end
            if (i_ctrl.flip) begin
                r_rev <= ~r_rev;
            end
            if (i_ctrl.fault) begin
                r_err <= 1'b1;
            end
            if (i_ctrl.remove) begin
                r_count <= r_count - 1'b1;
                if (!r_rev) begin
                    r_front <= head_next;
                end
            end
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.error    = r_err;
    assign o_removed_value = r_rd_live ? VALUE_W'(r_rd_data) : '0;
    assign o_count         = COUNT_W'(r_count);
    assign o_reversed      = r_rev;

endmodule

### rtl/core/deque_with_reverse_flag_core.sv
// bounded deque with lazy reverse flag, top level
// result: valid in the cycle after the request is accepted
// flow: the next request is taken only after the single result register has
//   been read out
// reset: synchronous active-low clears pointers, count, flags and handshake
//   state; the element store is not cleared and holds unknown data
module deque_with_reverse_flag_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_command,
    input  logic [dwr_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [dwr_pkg::VALUE_W-1:0] o_removed_value,
    output logic [dwr_pkg::COUNT_W-1:0] o_count,
    output logic                        o_reversed
);
    import dwr_pkg::*;

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    dwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_command   (i_command),
        .i_stat      (dp_stat),
        .o_ctrl      (dp_ctrl),
        .o_status    (o_status)
    );

    dwr_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (dp_ctrl),
        .i_value         (i_value),
        .o_stat          (dp_stat),
        .o_removed_value (o_removed_value),
        .o_count         (o_count),
        .o_reversed      (o_reversed)
    );

endmodule

### rtl/core/dwr_checker.sv
// port-level checks for the deque core, bound to the top level
module dwr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [1:0]                  i_command,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  o_status,
    input logic [dwr_pkg::VALUE_W-1:0] o_removed_value,
    input logic [dwr_pkg::COUNT_W-1:0] o_count,
    input logic                        o_reversed
);
    import dwr_pkg::*;

    // one request in flight: accept yields a result and blocks new requests
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (o_out_valid && !o_in_ready))
        else $error("accepted request did not produce a pending result");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command == CMD_CLEAR)
        |=> (o_status == ST_OK && o_count == '0 && !o_reversed))
        else $error("clear did not empty the deque");

    a_removed_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_removed_value != '0) |-> (o_status == ST_OK))
        else $error("nonzero removed value on a failed request");

    a_ignored_after_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_status == ST_EMPTY)
        ##1 (i_in_valid && o_in_ready && i_command != CMD_CLEAR)
        |=> (o_status == ST_IGNORED))
        else $error("request after empty delete was not ignored");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> (o_out_valid && $stable(o_status) && $stable(o_removed_value)
             && $stable(o_count) && $stable(o_reversed)))
        else $error("pending result changed before it was taken");

endmodule

bind deque_with_reverse_flag_core dwr_checker u_dwr_checker (.*);
